@@ rtl/core/imu_timestamp_pair_join_top_macros.svh @@
`ifndef IMU_TIMESTAMP_PAIR_JOIN_TOP_MACROS_SVH
`define IMU_TIMESTAMP_PAIR_JOIN_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define ITPJ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itpj check failed");

// next-cycle implication, checked outside reset
`define ITPJ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itpj check failed");

`endif

@@ rtl/core/itpj_pkg.sv @@
`default_nettype none

package itpj_pkg;

    localparam int FIFO_DEPTH = 16;
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);
    localparam int POS_W      = FILL_W + 1;

    typedef enum logic {
        OP_ACCEL = 1'b0,
        OP_GYRO  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_SHIFT1 = 2'd1,
        CELL_SHIFT2 = 2'd2,
        CELL_LOAD   = 2'd3
    } t_cell_sel;

    typedef struct packed {
        logic [63:0]        time_us;
        logic signed [15:0] temp;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_ctl;

    typedef struct packed {
        logic   nonempty;
        t_entry head;
    } t_fifo_stat;

    typedef struct packed {
        logic [63:0]        time_us;
        logic signed [15:0] temp;
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
        logic signed [31:0] gyro_x;
        logic signed [31:0] gyro_y;
        logic signed [31:0] gyro_z;
    } t_pair;

endpackage

`default_nettype wire

@@ rtl/core/itpj_cell.sv @@
`default_nettype none

module itpj_cell (
    input  wire logic                i_clk,
    input  wire itpj_pkg::t_cell_sel i_sel,
    input  wire itpj_pkg::t_entry    i_next1,
    input  wire itpj_pkg::t_entry    i_next2,
    input  wire itpj_pkg::t_entry    i_load,
    output itpj_pkg::t_entry         o_entry
);

    itpj_pkg::t_entry r_entry;
    itpj_pkg::t_entry n_entry;

    always_comb begin
        case (i_sel)
            itpj_pkg::CELL_HOLD:   n_entry = r_entry;
            itpj_pkg::CELL_SHIFT1: n_entry = i_next1;
            itpj_pkg::CELL_SHIFT2: n_entry = i_next2;
            itpj_pkg::CELL_LOAD:   n_entry = i_load;
            default:               n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

@@ rtl/core/itpj_fifo.sv @@
`default_nettype none

module itpj_fifo (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire itpj_pkg::t_fifo_ctl i_ctl,
    input  wire itpj_pkg::t_entry    i_sample,
    output itpj_pkg::t_fifo_stat     o_stat
);

    localparam int D = itpj_pkg::FIFO_DEPTH;
    localparam int FW = itpj_pkg::FILL_W;
    localparam int PW = itpj_pkg::POS_W;

    logic [FW-1:0]       r_fill;
    logic [FW-1:0]       n_fill;
    logic                drop;
    logic [FW-1:0]       fill_post;
    logic [1:0]          shift_cnt;
    itpj_pkg::t_entry    cells [D];
    itpj_pkg::t_cell_sel sel [D];

    assign drop      = i_ctl.push && (r_fill == FW'(D));
    assign fill_post = r_fill - FW'(drop);
    assign shift_cnt = {1'b0, drop} + {1'b0, i_ctl.pop};
    assign n_fill    = fill_post + FW'(i_ctl.push) - FW'(i_ctl.pop);

    assign o_stat.nonempty = i_ctl.push || (r_fill != '0);
    assign o_stat.head     = (i_ctl.push && fill_post == '0) ? i_sample
                           : (drop ? cells[1] : cells[0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    for (genvar j = 0; j < D; j++) begin : g_cell
        itpj_pkg::t_entry next1;
        itpj_pkg::t_entry next2;
        logic [PW-1:0]    pos;

        if (j + 1 < D) begin : g_n1
            assign next1 = cells[j+1];
        end else begin : g_n1_end
            assign next1 = i_sample;
        end
        if (j + 2 < D) begin : g_n2
            assign next2 = cells[j+2];
        end else begin : g_n2_end
            assign next2 = i_sample;
        end

        assign pos = PW'(j) + PW'(i_ctl.pop);

        always_comb begin
            if (i_ctl.push && pos == {1'b0, fill_post}) begin
                sel[j] = itpj_pkg::CELL_LOAD;
            end else begin
                case (shift_cnt)
                    2'd1:    sel[j] = itpj_pkg::CELL_SHIFT1;
                    2'd2:    sel[j] = itpj_pkg::CELL_SHIFT2;
                    default: sel[j] = itpj_pkg::CELL_HOLD;
                endcase
            end
        end

        itpj_cell u_cell (
            .i_clk   (i_clk),
            .i_sel   (sel[j]),
            .i_next1 (next1),
            .i_next2 (next2),
            .i_load  (i_sample),
            .o_entry (cells[j])
        );
    end

endmodule

`default_nettype wire

@@ rtl/core/imu_timestamp_pair_join_top.sv @@
// Joins accelerometer and gyroscope samples that carry the same timestamp.
// Input channel (i_in_valid / o_in_ready): one sample per request, i_opcode
// selects accel or gyro. Each sensor keeps a 16-entry queue built as a row of
// cells; the head is always in the first cell. A push into a full queue drops
// its oldest entry. After the push the two heads are compared once: equal
// timestamps give one paired result and pop both, otherwise the older head pops.
// Output channel (o_out_valid / i_out_ready): one paired result per request.
// A completing sample's result is registered into the output buffer. Throughput:
// one sample per cycle while o_in_ready is high; push, compare and shift of the
// cell rows act together. A two-entry output buffer keeps o_in_ready high while
// one result waits; o_in_ready drops only when two results are held.
// Configuration: i_cfg_wen writes i_cfg_wdata into the enable bit; samples taken
// while disabled are consumed and leave the queues untouched.
// Reset (synchronous, active low) empties both queues and the output buffer
// and clears enable.
`default_nettype none

module imu_timestamp_pair_join_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wen,
    input  wire logic               i_cfg_wdata,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_opcode,
    input  wire logic [63:0]        i_sample_time,
    input  wire logic signed [15:0] i_sample_temp,
    input  wire logic signed [31:0] i_axis_x,
    input  wire logic signed [31:0] i_axis_y,
    input  wire logic signed [31:0] i_axis_z,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [63:0]             o_pair_time,
    output logic signed [15:0]      o_pair_temp,
    output logic signed [31:0]      o_accel_x,
    output logic signed [31:0]      o_accel_y,
    output logic signed [31:0]      o_accel_z,
    output logic signed [31:0]      o_gyro_x,
    output logic signed [31:0]      o_gyro_y,
    output logic signed [31:0]      o_gyro_z
);

    logic                 r_enable;
    logic                 r_out_valid;
    logic                 r_skid_valid;
    itpj_pkg::t_pair      r_out;
    itpj_pkg::t_pair      r_skid;

    logic                 run;
    logic                 both;
    logic                 ts_eq;
    logic                 ts_lt;
    logic                 match;
    logic                 out_pop;
    itpj_pkg::t_entry     sample;
    itpj_pkg::t_fifo_ctl  a_ctl;
    itpj_pkg::t_fifo_ctl  g_ctl;
    itpj_pkg::t_fifo_stat a_stat;
    itpj_pkg::t_fifo_stat g_stat;
    itpj_pkg::t_pair      pair;

    assign o_in_ready = !r_skid_valid;
    assign run        = i_in_valid && o_in_ready && r_enable;

    assign sample.time_us = i_sample_time;
    assign sample.temp    = i_sample_temp;
    assign sample.x       = i_axis_x;
    assign sample.y       = i_axis_y;
    assign sample.z       = i_axis_z;

    assign a_ctl.push = run && (itpj_pkg::t_opcode'(i_opcode) == itpj_pkg::OP_ACCEL);
    assign g_ctl.push = run && (itpj_pkg::t_opcode'(i_opcode) == itpj_pkg::OP_GYRO);

    assign both  = run && a_stat.nonempty && g_stat.nonempty;
    assign ts_eq = a_stat.head.time_us == g_stat.head.time_us;
    assign ts_lt = a_stat.head.time_us <  g_stat.head.time_us;
    assign match = both && ts_eq;

    assign a_ctl.pop = both && (ts_eq || ts_lt);
    assign g_ctl.pop = both && !ts_lt;

    itpj_fifo u_accel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (a_ctl),
        .i_sample (sample),
        .o_stat   (a_stat)
    );

    itpj_fifo u_gyro (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (g_ctl),
        .i_sample (sample),
        .o_stat   (g_stat)
    );

    assign pair.time_us = a_stat.head.time_us;
    assign pair.temp    = a_stat.head.temp;
    assign pair.accel_x = a_stat.head.x;
    assign pair.accel_y = a_stat.head.y;
    assign pair.accel_z = a_stat.head.z;
    assign pair.gyro_x  = g_stat.head.x;
    assign pair.gyro_y  = g_stat.head.y;
    assign pair.gyro_z  = g_stat.head.z;

    assign out_pop = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_wen) begin
            r_enable <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || out_pop) begin
            r_out_valid <= match;
        end else if (match) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_pop) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || out_pop) begin
            if (match) begin
                r_out <= pair;
            end
        end else if (match) begin
            r_skid <= pair;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pair_time = r_out.time_us;
    assign o_pair_temp = r_out.temp;
    assign o_accel_x   = r_out.accel_x;
    assign o_accel_y   = r_out.accel_y;
    assign o_accel_z   = r_out.accel_z;
    assign o_gyro_x    = r_out.gyro_x;
    assign o_gyro_y    = r_out.gyro_y;
    assign o_gyro_z    = r_out.gyro_z;

endmodule

`default_nettype wire

@@ rtl/core/itpj_check.sv @@
`default_nettype none
`include "imu_timestamp_pair_join_top_macros.svh"

module itpj_check (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [63:0] o_pair_time
);

    `ITPJ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `ITPJ_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_pair_time))
    `ITPJ_ASSERT_NOW(a_no_invent, i_clk, i_rst_n, $rose(o_out_valid), $past(i_in_valid && o_in_ready))
    `ITPJ_ASSERT_NOW(a_stall_held, i_clk, i_rst_n, !o_in_ready, o_out_valid)

endmodule

bind imu_timestamp_pair_join_top itpj_check u_itpj_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_pair_time (o_pair_time)
);

`default_nettype wire

@@ tb/tb_imu_timestamp_pair_join_top.sv @@
`timescale 1ns / 1ps

class pair_scoreboard;
    bit                accel_dummy;
    bit                enabled;
    itpj_pkg::t_entry  accel_q[$];
    itpj_pkg::t_entry  gyro_q[$];
    itpj_pkg::t_pair   expected_q[$];
    int                fails;
    int                samples_taken;
    int                pairs_checked;
    int                drops;

    function void set_enable(bit v);
        enabled = v;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void note_request(itpj_pkg::t_opcode op, itpj_pkg::t_entry e);
        itpj_pkg::t_pair p;
        if (!enabled) return;
        samples_taken++;
        // drop oldest on overflow
        if (op == itpj_pkg::OP_ACCEL) begin
            if (accel_q.size() == itpj_pkg::FIFO_DEPTH) begin
                void'(accel_q.pop_front());
                drops++;
            end
            accel_q.push_back(e);
        end else begin
            if (gyro_q.size() == itpj_pkg::FIFO_DEPTH) begin
                void'(gyro_q.pop_front());
                drops++;
            end
            gyro_q.push_back(e);
        end
        if (accel_q.size() == 0 || gyro_q.size() == 0) return;
        if (accel_q[0].time_us == gyro_q[0].time_us) begin
            p.time_us = accel_q[0].time_us;
            p.temp    = accel_q[0].temp;
            p.accel_x = accel_q[0].x;
            p.accel_y = accel_q[0].y;
            p.accel_z = accel_q[0].z;
            p.gyro_x  = gyro_q[0].x;
            p.gyro_y  = gyro_q[0].y;
            p.gyro_z  = gyro_q[0].z;
            expected_q.push_back(p);
            void'(accel_q.pop_front());
            void'(gyro_q.pop_front());
        end else if (accel_q[0].time_us > gyro_q[0].time_us) begin
            void'(gyro_q.pop_front());
        end else begin
            void'(accel_q.pop_front());
        end
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            fails++;
        end
    endfunction

    function void check_pair(itpj_pkg::t_pair got);
        itpj_pkg::t_pair want;
        if (expected_q.size() == 0) begin
            $error("unexpected pair: pair_time %h", got.time_us);
            fails++;
            return;
        end
        want = expected_q.pop_front();
        pairs_checked++;
        compare_field("pair_time", want.time_us, got.time_us);
        compare_field("pair_temp", 64'(want.temp), 64'(got.temp));
        compare_field("accel_x", 64'(want.accel_x), 64'(got.accel_x));
        compare_field("accel_y", 64'(want.accel_y), 64'(got.accel_y));
        compare_field("accel_z", 64'(want.accel_z), 64'(got.accel_z));
        compare_field("gyro_x", 64'(want.gyro_x), 64'(got.gyro_x));
        compare_field("gyro_y", 64'(want.gyro_y), 64'(got.gyro_y));
        compare_field("gyro_z", 64'(want.gyro_z), 64'(got.gyro_z));
    endfunction
endclass

module tb_imu_timestamp_pair_join_top;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 10;

    logic              i_clk     = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_wen   = 1'b0;
    logic              cfg_wdata = 1'b0;
    logic              in_valid  = 1'b0;
    itpj_pkg::t_opcode in_opcode = itpj_pkg::OP_ACCEL;
    itpj_pkg::t_entry  in_entry  = '0;
    logic              out_ready = 1'b0;

    logic               o_in_ready;
    logic               o_out_valid;
    logic [63:0]        o_pair_time;
    logic signed [15:0] o_pair_temp;
    logic signed [31:0] o_accel_x;
    logic signed [31:0] o_accel_y;
    logic signed [31:0] o_accel_z;
    logic signed [31:0] o_gyro_x;
    logic signed [31:0] o_gyro_y;
    logic signed [31:0] o_gyro_z;

    pair_scoreboard sb;
    int          items_sent = 0;
    int          cfg_writes = 0;
    int          holds_done = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    bit          hold_req   = 1'b0;
    logic [63:0] clock_us;

    imu_timestamp_pair_join_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_cfg_wen     (cfg_wen),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (in_opcode),
        .i_sample_time (in_entry.time_us),
        .i_sample_temp (in_entry.temp),
        .i_axis_x      (in_entry.x),
        .i_axis_y      (in_entry.y),
        .i_axis_z      (in_entry.z),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_pair_time   (o_pair_time),
        .o_pair_temp   (o_pair_temp),
        .o_accel_x     (o_accel_x),
        .o_accel_y     (o_accel_y),
        .o_accel_z     (o_accel_z),
        .o_gyro_x      (o_gyro_x),
        .o_gyro_y      (o_gyro_y),
        .o_gyro_z      (o_gyro_z)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        itpj_pkg::t_pair got;
        if (rst_n) begin
            if (in_valid && o_in_ready) sb.note_request(in_opcode, in_entry);
            if (o_out_valid && out_ready) begin
                got.time_us = o_pair_time;
                got.temp    = o_pair_temp;
                got.accel_x = o_accel_x;
                got.accel_y = o_accel_y;
                got.accel_z = o_accel_z;
                got.gyro_x  = o_gyro_x;
                got.gyro_y  = o_gyro_y;
                got.gyro_z  = o_gyro_z;
                sb.check_pair(got);
            end
        end
    end

    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                stall_left = HOLD_CYCLES;
                hold_req   = 1'b0;
                holds_done++;
            end else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 18);
            end
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic itpj_pkg::t_entry make_entry(logic [63:0] t,
                                                    logic signed [15:0] temp,
                                                    logic signed [31:0] x,
                                                    logic signed [31:0] y,
                                                    logic signed [31:0] z);
        itpj_pkg::t_entry e;
        e.time_us = t;
        e.temp    = temp;
        e.x       = x;
        e.y       = y;
        e.z       = z;
        return e;
    endfunction

    function automatic itpj_pkg::t_entry random_entry(logic [63:0] t);
        return make_entry(t, 16'($urandom), 32'($urandom), 32'($urandom), 32'($urandom));
    endfunction

    task automatic send_sample(input itpj_pkg::t_opcode op, input itpj_pkg::t_entry e);
        in_valid  <= 1'b1;
        in_opcode <= op;
        in_entry  <= e;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic write_enable(input logic v);
        in_valid <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        sb.set_enable(v);
        cfg_writes++;
        @(posedge i_clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic run_directed();
        int k;
        send_sample(itpj_pkg::OP_ACCEL, make_entry(64'd0, 16'sh8000, 32'sh8000_0000,
                                                   32'sh8000_0000, 32'sh8000_0000));
        send_sample(itpj_pkg::OP_GYRO, make_entry(64'd0, 16'sh0000, 32'sh7fff_ffff,
                                                  32'sh7fff_ffff, 32'sh7fff_ffff));
        send_sample(itpj_pkg::OP_ACCEL, make_entry('1, 16'sh7fff, 32'sh7fff_ffff,
                                                   32'sh7fff_ffff, 32'sh7fff_ffff));
        send_sample(itpj_pkg::OP_GYRO, make_entry('1, 16'sh8000, 32'sh8000_0000,
                                                  32'sh8000_0000, 32'sh8000_0000));
        // older gyro head pops, then the match
        send_sample(itpj_pkg::OP_ACCEL, random_entry(64'd5));
        send_sample(itpj_pkg::OP_GYRO, random_entry(64'd3));
        send_sample(itpj_pkg::OP_GYRO, random_entry(64'd5));
        // overflow the accel queue by one
        for (k = 0; k <= itpj_pkg::FIFO_DEPTH; k++) begin
            send_sample(itpj_pkg::OP_ACCEL, random_entry(64'(100 + k)));
        end
        send_sample(itpj_pkg::OP_GYRO, random_entry(64'd101));
    endtask

    task automatic run_traffic(input int goal, input bit with_hold, input bit allow_idle);
        int start;
        int toggle_at;
        int mode;
        int n;
        int k;
        bit hold_sent;
        start     = items_sent;
        toggle_at = items_sent;
        hold_sent = 1'b0;
        if (!allow_idle) begin
            tx_idle_on = 1'b0;
            rx_idle_on = 1'b0;
        end
        while (items_sent - start < goal) begin
            if (allow_idle && items_sent - toggle_at >= 60) begin
                toggle_at  = items_sent;
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            if (with_hold && !hold_sent && items_sent - start >= goal / 2) begin
                hold_req  = 1'b1;
                hold_sent = 1'b1;
            end
            mode = $urandom_range(0, 99);
            if (mode < 4) clock_us = {$urandom, $urandom};
            clock_us += 64'($urandom_range(1, 40));
            if (mode < 64) begin
                if ($urandom_range(0, 1) == 0) begin
                    send_sample(itpj_pkg::OP_ACCEL, random_entry(clock_us));
                    send_sample(itpj_pkg::OP_GYRO, random_entry(clock_us));
                end else begin
                    send_sample(itpj_pkg::OP_GYRO, random_entry(clock_us));
                    send_sample(itpj_pkg::OP_ACCEL, random_entry(clock_us));
                end
            end else if (mode < 74) begin
                send_sample(itpj_pkg::OP_ACCEL, random_entry(clock_us));
            end else if (mode < 84) begin
                send_sample(itpj_pkg::OP_GYRO, random_entry(clock_us));
            end else if (mode < 92) begin
                send_sample(itpj_pkg::t_opcode'($urandom_range(0, 1)),
                            random_entry({$urandom, $urandom}));
            end else begin
                // backlog one side, then feed the other
                n = $urandom_range(2, 20);
                for (k = 0; k < n; k++) begin
                    send_sample(itpj_pkg::OP_ACCEL, random_entry(clock_us + 64'(k)));
                end
                for (k = 0; k < n; k++) begin
                    send_sample(itpj_pkg::OP_GYRO, random_entry(clock_us + 64'(k)));
                end
                clock_us += 64'(n);
            end
        end
    endtask

    initial begin
        sb = new();
        clock_us = {$urandom, $urandom};
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        run_traffic(4, 1'b0, 1'b1);
        write_enable(1'b1);
        run_directed();
        write_enable(1'b0);
        run_traffic(30, 1'b0, 1'b1);
        write_enable(1'b1);
        run_traffic(700, 1'b1, 1'b1);
        write_enable(1'b0);
        run_traffic(25, 1'b0, 1'b1);
        write_enable(1'b1);
        run_traffic(480, 1'b0, 1'b1);
        run_traffic(150, 1'b0, 1'b0);
        in_valid <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d pairs never arrived", sb.pending());
            sb.fails++;
        end
        $display("Run: %0d requests sent, %0d taken while enabled, %0d pairs checked.",
                 items_sent, sb.samples_taken, sb.pairs_checked);
        $display("Queue overflow drops %0d, enable writes %0d, long output stalls %0d.",
                 sb.drops, cfg_writes, holds_done);
        if (sb.fails == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
